### sv/periodic_task_dispatcher_defines.svh
// ---------------------------------------------------------------------------
// Periodic task dispatcher assertion macros
// Shared helpers for the concurrent checks of the dispatcher.
// ---------------------------------------------------------------------------
`ifndef PERIODIC_TASK_DISPATCHER_DEFINES_SVH
`define PERIODIC_TASK_DISPATCHER_DEFINES_SVH

// Check that holds in the same cycle as its condition.
`define PTD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("periodic_task_dispatcher: same-cycle check failed");

// Check that holds in the cycle after its condition.
`define PTD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("periodic_task_dispatcher: next-cycle check failed");

`endif

### sv/ptd_pkg.sv
// ---------------------------------------------------------------------------
// Periodic task dispatcher package
// Sizes, command and status codes, and the command word sent to every cell.
// ---------------------------------------------------------------------------
`default_nettype none

package ptd_pkg;

    localparam int SLOT_COUNT   = 8;
    localparam int PERIOD_BITS  = 32;
    localparam int SLOT_BITS    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int COUNT_BITS   = $clog2(SLOT_COUNT + 1);
    localparam int ELAPSED_BITS = 16;
    localparam int ID_BITS      = 8;
    localparam int CMP_BITS     = (PERIOD_BITS > ELAPSED_BITS) ? PERIOD_BITS : ELAPSED_BITS;

    localparam logic [2:0] MODE_TICK       = 3'd0;
    localparam logic [2:0] MODE_REGISTER   = 3'd1;
    localparam logic [2:0] MODE_SET_PERIOD = 3'd2;
    localparam logic [2:0] MODE_BLOCK      = 3'd3;
    localparam logic [2:0] MODE_READY      = 3'd4;
    localparam logic [2:0] MODE_QUERY      = 3'd5;

    localparam logic [2:0] ST_DISPATCH   = 3'd0;
    localparam logic [2:0] ST_IDLE       = 3'd1;
    localparam logic [2:0] ST_REGISTERED = 3'd2;
    localparam logic [2:0] ST_FULL       = 3'd3;
    localparam logic [2:0] ST_UPDATED    = 3'd4;
    localparam logic [2:0] ST_QUERY      = 3'd5;
    localparam logic [2:0] ST_BAD_SLOT   = 3'd6;

    typedef struct packed {
        logic                    tick;
        logic [ELAPSED_BITS-1:0] elapsed;
        logic                    reg_wr;
        logic                    set_per;
        logic                    set_rdy;
        logic                    clr_rdy;
        logic [SLOT_BITS-1:0]    sel;
        logic [COUNT_BITS-1:0]   count;
        logic [PERIOD_BITS-1:0]  period;
        logic [ID_BITS-1:0]      user_id;
        logic                    tok_clr;
    } t_cell_cmd;

endpackage

`default_nettype wire

### sv/ptd_cell.sv
// ---------------------------------------------------------------------------
// Periodic task dispatcher slot cell
// Holds one task slot and passes the dispatch token to its neighbor.
// ---------------------------------------------------------------------------
`default_nettype none

module ptd_cell (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic [ptd_pkg::SLOT_BITS-1:0]  i_index,
    input  wire ptd_pkg::t_cell_cmd             i_cmd,
    input  wire logic                           i_tok,
    input  wire logic                           i_later,
    output logic                                o_tok,
    output logic                                o_later,
    output logic                                o_hit,
    output logic                                o_tok_later,
    output logic                                o_ready,
    output logic [ptd_pkg::ID_BITS-1:0]         o_id
);

    logic                               r_tok;
    logic                               n_tok;
    logic [ptd_pkg::PERIOD_BITS-1:0]    r_cd;
    logic [ptd_pkg::PERIOD_BITS-1:0]    n_cd;
    logic [ptd_pkg::PERIOD_BITS-1:0]    r_period;
    logic [ptd_pkg::PERIOD_BITS-1:0]    n_period;
    logic                               r_ready;
    logic                               n_ready;
    logic [ptd_pkg::ID_BITS-1:0]        r_id;
    logic [ptd_pkg::ID_BITS-1:0]        n_id;
    logic                               w_registered;
    logic                               w_me;
    logic                               w_due;
    logic                               w_hit;
    logic [ptd_pkg::CMP_BITS-1:0]       w_cd_ext;
    logic [ptd_pkg::CMP_BITS-1:0]       w_el_ext;
    logic [ptd_pkg::PERIOD_BITS-1:0]    w_dec;

    assign w_registered = int'(i_index) < int'(i_cmd.count);
    assign w_me         = (i_index == i_cmd.sel);
    assign w_due        = w_registered && r_ready && (r_cd == '0);
    assign w_hit        = r_tok && w_due;
    assign w_cd_ext     = ptd_pkg::CMP_BITS'(r_cd);
    assign w_el_ext     = ptd_pkg::CMP_BITS'(i_cmd.elapsed);
    assign w_dec        = (w_cd_ext > w_el_ext) ?
                          ptd_pkg::PERIOD_BITS'(w_cd_ext - w_el_ext) : '0;

    always_comb begin
        n_tok    = i_tok && !i_cmd.tok_clr;
        n_cd     = r_cd;
        n_period = r_period;
        n_ready  = r_ready;
        n_id     = r_id;
        if (i_cmd.reg_wr && w_me) begin
            n_cd = '0;
        end else if (w_hit) begin
            n_cd = r_period;
        end else if (i_cmd.tick && w_registered && (r_cd != '0)) begin
            n_cd = w_dec;
        end
        if ((i_cmd.reg_wr || i_cmd.set_per) && w_me) begin
            n_period = i_cmd.period;
        end
        if ((i_cmd.reg_wr || i_cmd.set_rdy) && w_me) begin
            n_ready = 1'b1;
        end else if (i_cmd.clr_rdy && w_me) begin
            n_ready = 1'b0;
        end
        if (i_cmd.reg_wr && w_me) begin
            n_id = i_cmd.user_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
        end else begin
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cd     <= n_cd;
        r_period <= n_period;
        r_ready  <= n_ready;
        r_id     <= n_id;
    end

    assign o_tok       = r_tok;
    assign o_later     = w_due || i_later;
    assign o_hit       = w_hit;
    assign o_tok_later = r_tok && i_later;
    assign o_ready     = r_ready;
    assign o_id        = r_tok ? r_id : '0;

endmodule

`default_nettype wire

### sv/periodic_task_dispatcher.sv
// Every command but a nonzero tick gives its one result word in the cycle after acceptance.
// A tick with nonzero elapsed ticks counts down in its accept cycle, then a token walks
// the slot cells one per cycle, with at most one result word per cycle, and the module
// stays busy until the walk stops at the last due slot.
// Synchronous reset empties the table and clears busy, the token and the strobe.
// ---------------------------------------------------------------------------
// Periodic task dispatcher
// Task slot table built as a row of cells with a token-driven dispatch scan.
// ---------------------------------------------------------------------------
`default_nettype none

`include "periodic_task_dispatcher_defines.svh"

module periodic_task_dispatcher (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [2:0]                         i_mode,
    input  wire logic [ptd_pkg::ELAPSED_BITS-1:0]   i_elapsed_ticks,
    input  wire logic [2:0]                         i_slot,
    input  wire logic [ptd_pkg::ID_BITS-1:0]        i_user_id,
    input  wire logic [31:0]                        i_period,
    output logic                                    o_valid,
    output logic [2:0]                              o_status,
    output logic [2:0]                              o_result_slot,
    output logic [ptd_pkg::ID_BITS-1:0]             o_result_id,
    output logic                                    o_is_ready,
    output logic                                    o_last
);

    logic                               r_busy;
    logic                               n_busy;
    logic [ptd_pkg::SLOT_BITS-1:0]      r_idx;
    logic [ptd_pkg::SLOT_BITS-1:0]      n_idx;
    logic [ptd_pkg::COUNT_BITS-1:0]     r_count;
    logic [ptd_pkg::COUNT_BITS-1:0]     n_count;
    logic                               r_valid;
    logic                               n_valid;
    logic [2:0]                         r_status;
    logic [2:0]                         n_status;
    logic [2:0]                         r_rslot;
    logic [2:0]                         n_rslot;
    logic [ptd_pkg::ID_BITS-1:0]        r_rid;
    logic [ptd_pkg::ID_BITS-1:0]        n_rid;
    logic                               r_rdy;
    logic                               n_rdy;
    logic                               r_last;
    logic                               n_last;

    ptd_pkg::t_cell_cmd                 w_cmd;
    logic                               w_acc;
    logic                               w_inject;
    logic                               w_hit;
    logic                               w_later;
    logic [ptd_pkg::ID_BITS-1:0]        w_id;
    logic [ptd_pkg::SLOT_BITS-1:0]      w_sel;
    logic                               w_bad;

    logic [ptd_pkg::SLOT_COUNT-1:0]     w_tok_in;
    logic [ptd_pkg::SLOT_COUNT-1:0]     w_tok;
    logic [ptd_pkg::SLOT_COUNT-1:0]     w_later_in;
    logic [ptd_pkg::SLOT_COUNT-1:0]     w_later_out;
    logic [ptd_pkg::SLOT_COUNT-1:0]     w_hit_vec;
    logic [ptd_pkg::SLOT_COUNT-1:0]     w_tok_later;
    logic [ptd_pkg::SLOT_COUNT-1:0]     w_ready;
    logic [ptd_pkg::ID_BITS-1:0]        w_ids [ptd_pkg::SLOT_COUNT];

    genvar g;
    generate
        for (g = 0; g < ptd_pkg::SLOT_COUNT; g++) begin : g_cell
            if (g == 0) begin : g_head
                assign w_tok_in[g] = w_inject;
            end else begin : g_body
                assign w_tok_in[g] = w_tok[g-1];
            end
            if (g == ptd_pkg::SLOT_COUNT - 1) begin : g_tail
                assign w_later_in[g] = 1'b0;
            end else begin : g_mid
                assign w_later_in[g] = w_later_out[g+1];
            end
            ptd_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_index     (ptd_pkg::SLOT_BITS'(g)),
                .i_cmd       (w_cmd),
                .i_tok       (w_tok_in[g]),
                .i_later     (w_later_in[g]),
                .o_tok       (w_tok[g]),
                .o_later     (w_later_out[g]),
                .o_hit       (w_hit_vec[g]),
                .o_tok_later (w_tok_later[g]),
                .o_ready     (w_ready[g]),
                .o_id        (w_ids[g])
            );
        end
    endgenerate

    assign w_acc   = start && !r_busy;
    assign w_hit   = |w_hit_vec;
    assign w_later = |w_tok_later;
    assign w_sel   = ptd_pkg::SLOT_BITS'(i_slot);
    assign w_bad   = int'(i_slot) >= int'(r_count);

    always_comb begin
        w_id = '0;
        for (int k = 0; k < ptd_pkg::SLOT_COUNT; k++) begin
            w_id = w_id | w_ids[k];
        end
    end

    always_comb begin
        w_cmd         = '0;
        w_cmd.elapsed = i_elapsed_ticks;
        w_cmd.count   = r_count;
        w_cmd.period  = ptd_pkg::PERIOD_BITS'(i_period);
        w_cmd.user_id = i_user_id;
        w_cmd.sel     = w_sel;
        w_inject      = 1'b0;
        n_busy        = r_busy;
        n_idx         = r_idx;
        n_count       = r_count;
        n_valid       = 1'b0;
        n_status      = r_status;
        n_rslot       = r_rslot;
        n_rid         = r_rid;
        n_rdy         = r_rdy;
        n_last        = r_last;
        if (r_busy) begin
            n_idx = ptd_pkg::SLOT_BITS'(r_idx + 1'b1);
            if (w_hit) begin
                n_valid  = 1'b1;
                n_status = ptd_pkg::ST_DISPATCH;
                n_rslot  = 3'(r_idx);
                n_rid    = w_id;
                n_rdy    = 1'b0;
                n_last   = !w_later;
            end else if (!w_later) begin
                n_valid  = 1'b1;
                n_status = ptd_pkg::ST_IDLE;
                n_rslot  = '0;
                n_rid    = '0;
                n_rdy    = 1'b0;
                n_last   = 1'b1;
            end
            if (!w_later) begin
                n_busy        = 1'b0;
                w_cmd.tok_clr = 1'b1;
            end
        end else if (w_acc) begin
            n_rslot = '0;
            n_rid   = '0;
            n_rdy   = 1'b0;
            n_last  = 1'b1;
            unique case (i_mode)
                ptd_pkg::MODE_TICK: begin
                    if (i_elapsed_ticks != '0) begin
                        w_cmd.tick = 1'b1;
                        w_inject   = 1'b1;
                        n_busy     = 1'b1;
                        n_idx      = '0;
                    end else begin
                        n_valid  = 1'b1;
                        n_status = ptd_pkg::ST_IDLE;
                    end
                end
                ptd_pkg::MODE_REGISTER: begin
                    n_valid = 1'b1;
                    if (int'(r_count) < ptd_pkg::SLOT_COUNT) begin
                        w_cmd.reg_wr = 1'b1;
                        w_cmd.sel    = ptd_pkg::SLOT_BITS'(r_count);
                        n_count      = ptd_pkg::COUNT_BITS'(r_count + 1'b1);
                        n_status     = ptd_pkg::ST_REGISTERED;
                        n_rslot      = 3'(r_count);
                    end else begin
                        n_status = ptd_pkg::ST_FULL;
                    end
                end
                ptd_pkg::MODE_SET_PERIOD, ptd_pkg::MODE_BLOCK,
                ptd_pkg::MODE_READY, ptd_pkg::MODE_QUERY: begin
                    n_valid = 1'b1;
                    n_rslot = i_slot;
                    if (w_bad) begin
                        n_status = ptd_pkg::ST_BAD_SLOT;
                    end else if (i_mode == ptd_pkg::MODE_QUERY) begin
                        n_status = ptd_pkg::ST_QUERY;
                        n_rdy    = w_ready[w_sel];
                    end else begin
                        n_status      = ptd_pkg::ST_UPDATED;
                        w_cmd.set_per = (i_mode == ptd_pkg::MODE_SET_PERIOD);
                        w_cmd.clr_rdy = (i_mode == ptd_pkg::MODE_BLOCK);
                        w_cmd.set_rdy = (i_mode == ptd_pkg::MODE_READY);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_idx   <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_idx   <= n_idx;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_rslot  <= n_rslot;
        r_rid    <= n_rid;
        r_rdy    <= n_rdy;
        r_last   <= n_last;
    end

    assign busy          = r_busy;
    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_result_slot = r_rslot;
    assign o_result_id   = r_rid;
    assign o_is_ready    = r_rdy;
    assign o_last        = r_last;

    `PTD_ASSERT_NOW(a_one_token, i_clk, i_rst_n, r_busy, $onehot(w_tok))
    `PTD_ASSERT_NOW(a_no_token, i_clk, i_rst_n, !r_busy, w_tok == '0)
    `PTD_ASSERT_NOW(a_scan_end, i_clk, i_rst_n, $fell(r_busy), r_valid && r_last)
    `PTD_ASSERT_NEXT(a_quiet_tick, i_clk, i_rst_n,
        w_acc && (i_mode == ptd_pkg::MODE_TICK) && (i_elapsed_ticks == '0),
        r_valid && r_last && (r_status == ptd_pkg::ST_IDLE))

endmodule

`default_nettype wire
